@@ src/pbbd_pkg.sv @@
package pbbd_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 6;
    localparam int MaskW    = 6;
    localparam int ModeW    = 2;
    localparam int CoefW    = 5;
    localparam int ChanW    = 6;
    localparam int ProdW    = ChanW + CoefW;
    localparam int SumW     = ProdW + 1;
    localparam int FracW    = 4;

    localparam logic [CfgIdxW-1:0] CFG_TOP_MASK = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MODE     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_BOT_MASK = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_COEF_TOP = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_COEF_BOT = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_COEF_FADE = 3'd5;

    localparam logic [ModeW-1:0] MODE_NONE   = 2'd0;
    localparam logic [ModeW-1:0] MODE_ALPHA  = 2'd1;
    localparam logic [ModeW-1:0] MODE_BRIGHT = 2'd2;
    localparam logic [ModeW-1:0] MODE_DARK   = 2'd3;

    localparam logic [CoefW-1:0] WEIGHT_ONE = 5'd16;
    localparam logic [ChanW-1:0] LIM_5BIT   = 6'd31;
    localparam logic [ChanW-1:0] LIM_6BIT   = 6'd63;

    typedef struct packed {
        logic [ChanW-1:0] a;
        logic [ChanW-1:0] b;
        logic [CoefW-1:0] wa;
        logic [CoefW-1:0] wb;
    } t_mix_op;

    function automatic logic [CoefW-1:0] clamp16(input logic [CoefW-1:0] w);
        clamp16 = (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] c);
        widen5 = {c, c[4:2]};
    endfunction

endpackage

@@ src/pixel_blend_brighten_darken.sv @@
// an accepted beat reaches o_strobe through three register stages: decode, multiply, sum
// throughput: one pixel per clock; busy stays low, so every stage advances each cycle
// reset (synchronous, active low) clears the pipeline valid bits and all configuration
// registers to zero
module pixel_blend_brighten_darken
    import pbbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic [15:0]         i_top_color,
    input  logic [15:0]         i_bottom_color,
    input  logic [2:0]          i_top_layer,
    input  logic [2:0]          i_bottom_layer,
    input  logic                i_window_blend_enable,
    input  logic                i_sprite_semi_transparent,
    output logic                o_strobe,
    output logic [7:0]          o_out_red,
    output logic [7:0]          o_out_green,
    output logic [7:0]          o_out_blue
);

    logic [MaskW-1:0] r_top_mask;
    logic [ModeW-1:0] r_mode;
    logic [MaskW-1:0] r_bot_mask;
    logic [CoefW-1:0] r_coef_top;
    logic [CoefW-1:0] r_coef_bot;
    logic [CoefW-1:0] r_coef_fade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_mask  <= '0;
            r_mode      <= MODE_NONE;
            r_bot_mask  <= '0;
            r_coef_top  <= '0;
            r_coef_bot  <= '0;
            r_coef_fade <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOP_MASK:  r_top_mask  <= i_cfg_wdata[MaskW-1:0];
                CFG_MODE:      r_mode      <= i_cfg_wdata[ModeW-1:0];
                CFG_BOT_MASK:  r_bot_mask  <= i_cfg_wdata[MaskW-1:0];
                CFG_COEF_TOP:  r_coef_top  <= i_cfg_wdata[CoefW-1:0];
                CFG_COEF_BOT:  r_coef_bot  <= i_cfg_wdata[CoefW-1:0];
                CFG_COEF_FADE: r_coef_fade <= i_cfg_wdata[CoefW-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // decode stage
    logic [7:0]       top_mask8;
    logic [7:0]       bot_mask8;
    logic             top_ok;
    logic             bot_ok;
    logic             apply;
    logic [ModeW-1:0] mode;
    logic [ChanW-1:0] t_r, t_g, t_b;
    logic [ChanW-1:0] b_r, b_g, b_b;
    logic [ChanW-1:0] k_5, k_6;
    logic [CoefW-1:0] wy;
    t_mix_op          n_op_r, n_op_g, n_op_b;

    always_comb begin
        top_mask8 = {2'b00, r_top_mask};
        bot_mask8 = {2'b00, r_bot_mask};
        top_ok    = top_mask8[i_top_layer];
        bot_ok    = bot_mask8[i_bottom_layer];
        mode      = r_mode;
        apply     = i_window_blend_enable && top_ok && (bot_ok || (r_mode != MODE_ALPHA));
        if (i_sprite_semi_transparent &&
            ((top_ok && bot_ok) || (!top_ok && (r_bot_mask != '0)))) begin
            mode  = MODE_ALPHA;
            apply = 1'b1;
        end

        t_r = {1'b0, i_top_color[4:0]};
        t_g = {i_top_color[9:5], i_top_color[15]};
        t_b = {1'b0, i_top_color[14:10]};
        b_r = {1'b0, i_bottom_color[4:0]};
        b_g = {i_bottom_color[9:5], i_bottom_color[15]};
        b_b = {1'b0, i_bottom_color[14:10]};

        wy = clamp16(r_coef_fade);
        k_5 = (mode == MODE_BRIGHT) ? LIM_5BIT : '0;
        k_6 = (mode == MODE_BRIGHT) ? LIM_6BIT : '0;

        // pass-through: weight one on top, nothing on the other side
        n_op_r = '{a: t_r, b: '0, wa: WEIGHT_ONE, wb: '0};
        n_op_g = '{a: t_g, b: '0, wa: WEIGHT_ONE, wb: '0};
        n_op_b = '{a: t_b, b: '0, wa: WEIGHT_ONE, wb: '0};
        if (apply) begin
            unique case (mode)
                MODE_ALPHA: begin
                    n_op_r = '{a: t_r, b: b_r, wa: clamp16(r_coef_top), wb: clamp16(r_coef_bot)};
                    n_op_g = '{a: t_g, b: b_g, wa: clamp16(r_coef_top), wb: clamp16(r_coef_bot)};
                    n_op_b = '{a: t_b, b: b_b, wa: clamp16(r_coef_top), wb: clamp16(r_coef_bot)};
                end
                MODE_BRIGHT, MODE_DARK: begin
                    n_op_r = '{a: t_r, b: k_5, wa: WEIGHT_ONE - wy, wb: wy};
                    n_op_g = '{a: t_g, b: k_6, wa: WEIGHT_ONE - wy, wb: wy};
                    n_op_b = '{a: t_b, b: k_5, wa: WEIGHT_ONE - wy, wb: wy};
                end
                default: ;
            endcase
        end
    end

    logic    r_v1;
    t_mix_op r_op_r, r_op_g, r_op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_r <= n_op_r;
        r_op_g <= n_op_g;
        r_op_b <= n_op_b;
    end

    logic             v_r, v_g, v_b;
    logic [ChanW-1:0] c_r, c_g, c_b;

    pbbd_mix u_mix_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_op    (r_op_r),
        .i_lim   (LIM_5BIT),
        .o_valid (v_r),
        .o_val   (c_r)
    );

    pbbd_mix u_mix_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_op    (r_op_g),
        .i_lim   (LIM_6BIT),
        .o_valid (v_g),
        .o_val   (c_g)
    );

    pbbd_mix u_mix_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_op    (r_op_b),
        .i_lim   (LIM_5BIT),
        .o_valid (v_b),
        .o_val   (c_b)
    );

    assign o_strobe    = v_r;
    assign o_out_red   = widen5(c_r[4:0]);
    assign o_out_green = widen5(c_g[5:1]);
    assign o_out_blue  = widen5(c_b[4:0]);

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_r == v_g) && (v_r == v_b))
        else $error("channel lanes out of step");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##3 o_strobe)
        else $error("accepted beat not strobed after three cycles");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 3))
        else $error("strobe without accepted beat");

endmodule

@@ src/pbbd_mix.sv @@
module pbbd_mix
    import pbbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_mix_op          i_op,
    input  logic [ChanW-1:0] i_lim,
    output logic             o_valid,
    output logic [ChanW-1:0] o_val
);

    logic [ProdW-1:0] r_pa;
    logic [ProdW-1:0] r_pb;
    logic             r_vp;
    logic [ChanW-1:0] r_val;
    logic             r_vo;

    logic [SumW-1:0]        n_sum;
    logic [SumW-FracW-1:0]  n_floor;
    logic [ChanW-1:0]       n_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_vp <= i_valid;
            r_vo <= r_vp;
        end
    end

    // weighted products
    always_ff @(posedge i_clk) begin
        r_pa <= ProdW'(i_op.a) * ProdW'(i_op.wa);
        r_pb <= ProdW'(i_op.b) * ProdW'(i_op.wb);
    end

    // sum, floor, saturate
    always_comb begin
        n_sum   = SumW'(r_pa) + SumW'(r_pb);
        n_floor = n_sum[SumW-1:FracW];
        n_val   = (n_floor > (SumW-FracW)'(i_lim)) ? i_lim : n_floor[ChanW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_valid = r_vo;
    assign o_val   = r_val;

    a_val_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vp |=> (r_val <= $past(i_lim)))
        else $error("mix result above saturation limit");

    a_valid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##2 r_vo)
        else $error("mix beat lost");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> $past(i_valid, 2))
        else $error("mix beat invented");

endmodule
